// ===== sv/qnl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qnl_pkg;

   // width of the square root and divide datapath
   localparam int ACC_W = 64;
   localparam int LEN_W = 32;
   localparam int ROOT_STEPS = ACC_W / 2;

   // fixed widths of the channel fields
   localparam int FIELD_W = 16;
   localparam int BF_W = 15;
   localparam int RSP_W = 16;
   localparam int RSP_MAX = 32767;
   localparam int RSP_MIN = -32768;

endpackage
`default_nettype wire

// ===== sv/quaternion_nlerp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shortest-arc normalized blend of two quaternions, signed fixed point.
// Input channel req_*: quaternions a and b plus a blend factor, one item
// per transfer. Result channel rsp_*: the normalized blend, one result for
// every input item, in order.
// Each of the three normalizers spends 32 stages on the square root (one
// root bit per stage) and FRAC_BITS+1 stages on the divide (one quotient
// bit per stage); dot product and mix add four more.
// Throughput is one item per cycle: req_ready is high whenever the output
// register is empty or being taken.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated and
// the pipeline resumes in place once the result is taken.
// Reset clears every valid bit; the datapath itself carries no reset.
module quaternion_nlerp_unit
   import qnl_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [FIELD_W-1:0] req_a_x,
   input  wire logic signed [FIELD_W-1:0] req_a_y,
   input  wire logic signed [FIELD_W-1:0] req_a_z,
   input  wire logic signed [FIELD_W-1:0] req_a_w,
   input  wire logic signed [FIELD_W-1:0] req_b_x,
   input  wire logic signed [FIELD_W-1:0] req_b_y,
   input  wire logic signed [FIELD_W-1:0] req_b_z,
   input  wire logic signed [FIELD_W-1:0] req_b_w,
   input  wire logic [BF_W-1:0]           req_blend_factor,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [RSP_W-1:0]        rsp_r_x,
   output logic signed [RSP_W-1:0]        rsp_r_y,
   output logic signed [RSP_W-1:0]        rsp_r_z,
   output logic signed [RSP_W-1:0]        rsp_r_w
);

   localparam int N_W = FRAC_BITS + 2;
   localparam int T_W = FRAC_BITS + 1;
   localparam int TC_W = (BF_W > T_W) ? BF_W : T_W;
   localparam int DP_W = 2 * N_W;
   localparam int DS_W = DP_W + 2;
   localparam int P_W = N_W + T_W + 1;
   localparam int M_W = P_W + 1;
   localparam int C_W = N_W + RSP_W;
   localparam int OUT_GUARD = 31 - FRAC_BITS;
   localparam logic [TC_W-1:0] ONE_C = TC_W'(1) << FRAC_BITS;
   localparam logic [M_W-1:0] HALF_C = M_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [C_W-1:0] RMAX_C = C_W'(RSP_MAX);
   localparam logic signed [C_W-1:0] RMIN_C = C_W'(RSP_MIN);

   logic advance;
   logic rsp_valid_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // blend factor saturates at one
   logic [TC_W-1:0] bf_wide;
   logic [T_W-1:0]  t_in;

   always_comb begin
      bf_wide = TC_W'(req_blend_factor);
      t_in = (bf_wide > ONE_C) ? T_W'(ONE_C) : T_W'(bf_wide);
   end

   logic signed [FIELD_W-1:0] a_vec [4];
   logic signed [FIELD_W-1:0] b_vec [4];
   logic signed [N_W-1:0]     na [4];
   logic signed [N_W-1:0]     nb [4];
   logic [T_W-1:0]            n_t;
   logic                      n_valid;

   assign a_vec = '{req_a_x, req_a_y, req_a_z, req_a_w};
   assign b_vec = '{req_b_x, req_b_y, req_b_z, req_b_w};

   // t rides with a, the valid bit with b
   qnl_norm #(
      .IN_W(FIELD_W), .GUARD(15), .FRAC_BITS(FRAC_BITS), .SIDE_W(T_W), .OUT_W(N_W)
   ) u_norm_a (
      .clock(clock), .reset(reset), .enable(advance),
      .vec_in(a_vec), .side_in(t_in), .vec_out(na), .side_out(n_t)
   );

   qnl_norm #(
      .IN_W(FIELD_W), .GUARD(15), .FRAC_BITS(FRAC_BITS), .SIDE_W(1), .OUT_W(N_W)
   ) u_norm_b (
      .clock(clock), .reset(reset), .enable(advance),
      .vec_in(b_vec), .side_in(req_valid), .vec_out(nb), .side_out(n_valid)
   );

   // dot product terms
   logic                  d1_valid_ff;
   logic signed [N_W-1:0] d1_na_ff [4];
   logic signed [N_W-1:0] d1_nb_ff [4];
   logic [T_W-1:0]        d1_t_ff;
   logic signed [DP_W-1:0] d1_p_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_na_ff <= na;
         d1_nb_ff <= nb;
         d1_t_ff <= n_t;
         for (int i = 0; i < 4; i++) begin
            d1_p_ff[i] <= DP_W'(na[i]) * DP_W'(nb[i]);
         end
      end
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (advance) begin
         d1_valid_ff <= n_valid;
      end
   end

   // dot product sign picks the shorter arc
   logic signed [DS_W-1:0] dot_in;
   logic                   d2_valid_ff;
   logic signed [N_W-1:0]  d2_na_ff [4];
   logic signed [N_W-1:0]  d2_nb_ff [4];
   logic [T_W-1:0]         d2_t_ff;
   logic                   d2_flip_ff;

   assign dot_in = DS_W'(d1_p_ff[0]) + DS_W'(d1_p_ff[1]) + DS_W'(d1_p_ff[2])
                 + DS_W'(d1_p_ff[3]);

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_na_ff <= d1_na_ff;
         d2_nb_ff <= d1_nb_ff;
         d2_t_ff <= d1_t_ff;
         d2_flip_ff <= dot_in[DS_W-1];
      end
      if (reset) begin
         d2_valid_ff <= 1'b0;
      end else if (advance) begin
         d2_valid_ff <= d1_valid_ff;
      end
   end

   // mix products
   logic signed [T_W:0]   t_s;
   logic signed [T_W:0]   omt_s;
   logic signed [N_W-1:0] nbs_in [4];
   logic                  m1_valid_ff;
   logic signed [P_W-1:0] m1_pa_ff [4];
   logic signed [P_W-1:0] m1_pb_ff [4];

   always_comb begin
      t_s = $signed({1'b0, d2_t_ff});
      omt_s = $signed({1'b0, T_W'(ONE_C) - d2_t_ff});
      for (int i = 0; i < 4; i++) begin
         nbs_in[i] = d2_flip_ff ? -d2_nb_ff[i] : d2_nb_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            m1_pa_ff[i] <= P_W'(d2_na_ff[i]) * P_W'(omt_s);
            m1_pb_ff[i] <= P_W'(nbs_in[i]) * P_W'(t_s);
         end
      end
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= d2_valid_ff;
      end
   end

   // sum and round back to FRAC_BITS fraction bits
   logic signed [M_W-1:0] m_sum [4];
   logic [M_W-1:0]        m_mag [4];
   logic [M_W-1:0]        m_rnd [4];
   logic signed [N_W-1:0] mix_in [4];
   logic                  m2_valid_ff;
   logic signed [N_W-1:0] m2_mix_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m_sum[i] = M_W'(m1_pa_ff[i]) + M_W'(m1_pb_ff[i]);
         m_mag[i] = m_sum[i][M_W-1] ? M_W'(-m_sum[i]) : M_W'(m_sum[i]);
         m_rnd[i] = (m_mag[i] + HALF_C) >> FRAC_BITS;
         mix_in[i] = m_sum[i][M_W-1] ? -N_W'(m_rnd[i]) : N_W'(m_rnd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_mix_ff <= mix_in;
      end
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   logic signed [N_W-1:0] o_vec [4];
   logic                  o_valid;

   qnl_norm #(
      .IN_W(N_W), .GUARD(OUT_GUARD), .FRAC_BITS(FRAC_BITS), .SIDE_W(1), .OUT_W(N_W)
   ) u_norm_mix (
      .clock(clock), .reset(reset), .enable(advance),
      .vec_in(m2_mix_ff), .side_in(m2_valid_ff), .vec_out(o_vec), .side_out(o_valid)
   );

   // output register with saturation to the field width
   logic signed [C_W-1:0]   o_wide [4];
   logic signed [RSP_W-1:0] r_in [4];
   logic signed [RSP_W-1:0] rsp_r_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         o_wide[i] = C_W'(o_vec[i]);
         if (o_wide[i] > RMAX_C) begin
            r_in[i] = RMAX_C[RSP_W-1:0];
         end else if (o_wide[i] < RMIN_C) begin
            r_in[i] = RMIN_C[RSP_W-1:0];
         end else begin
            r_in[i] = o_wide[i][RSP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_r_ff <= r_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= o_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_r_x = rsp_r_ff[0];
   assign rsp_r_y = rsp_r_ff[1];
   assign rsp_r_z = rsp_r_ff[2];
   assign rsp_r_w = rsp_r_ff[3];

endmodule
`default_nettype wire

// ===== sv/qnl_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qnl_norm
   import qnl_pkg::*;
#(
   parameter int IN_W = 16,
   parameter int GUARD = 15,
   parameter int FRAC_BITS = 14,
   parameter int SIDE_W = 1,
   parameter int OUT_W = FRAC_BITS + 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic signed [IN_W-1:0] vec_in [4],
   input  wire logic [SIDE_W-1:0]      side_in,
   output logic signed [OUT_W-1:0]     vec_out [4],
   output logic [SIDE_W-1:0]           side_out
);

   localparam int QD = FRAC_BITS + 1;
   localparam int Q_W = QD + 1;
   localparam int SQ_W = 2 * IN_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int SH_W = SUM_W + 2 * GUARD + ACC_W;
   localparam int NUM_SH = FRAC_BITS + GUARD;
   localparam int NUM_W = IN_W + NUM_SH + ACC_W;
   localparam int DIV_W = ACC_W + 1;

   typedef struct packed {
      logic [3:0]           neg;
      logic [3:0][IN_W-1:0] mag;
      logic                 zero;
   } hdr_type;

   // squares
   hdr_type          h1_in;
   logic [SQ_W-1:0]  sq_in [4];
   hdr_type          h1_ff;
   logic [SQ_W-1:0]  sq_ff [4];
   logic [SIDE_W-1:0] s1_ff;

   always_comb begin
      h1_in = '0;
      for (int i = 0; i < 4; i++) begin
         h1_in.neg[i] = vec_in[i][IN_W-1];
         h1_in.mag[i] = vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
         sq_in[i] = SQ_W'(h1_in.mag[i]) * SQ_W'(h1_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         h1_ff <= h1_in;
         sq_ff <= sq_in;
      end
      if (reset) begin
         s1_ff <= '0;
      end else if (enable) begin
         s1_ff <= side_in;
      end
   end

   // sum of squares, scaled for the root
   logic [SUM_W-1:0] sum_in;
   logic [SH_W-1:0]  sh_in;
   hdr_type          h2_in;

   logic [ACC_W-1:0]  rv_ff [ROOT_STEPS];
   logic [ACC_W-1:0]  rr_ff [ROOT_STEPS+1];
   hdr_type           rh_ff [ROOT_STEPS+1];
   logic [SIDE_W-1:0] rs_ff [ROOT_STEPS+1];

   always_comb begin
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      sh_in = SH_W'(sum_in) << (2 * GUARD);
      h2_in = h1_ff;
      h2_in.zero = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rv_ff[0] <= sh_in[ACC_W-1:0];
         rr_ff[0] <= '0;
         rh_ff[0] <= h2_in;
      end
      if (reset) begin
         rs_ff[0] <= '0;
      end else if (enable) begin
         rs_ff[0] <= s1_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [ACC_W-1:0] BIT_C = ACC_W'(1) << (ACC_W - 2 - 2 * k);
      logic [ACC_W:0]   trial;
      logic             take;
      logic [ACC_W-1:0] r_in;

      always_comb begin
         trial = {1'b0, rr_ff[k]} + {1'b0, BIT_C};
         take = ({1'b0, rv_ff[k]} >= trial);
         r_in = take ? ((rr_ff[k] >> 1) + BIT_C) : (rr_ff[k] >> 1);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rr_ff[k+1] <= r_in;
            rh_ff[k+1] <= rh_ff[k];
         end
         if (reset) begin
            rs_ff[k+1] <= '0;
         end else if (enable) begin
            rs_ff[k+1] <= rs_ff[k];
         end
      end

      if (k + 1 < ROOT_STEPS) begin : g_rem
         logic [ACC_W-1:0] v_in;
         assign v_in = take ? (rv_ff[k] - trial[ACC_W-1:0]) : rv_ff[k];
         always_ff @(posedge clock) begin
            if (enable) begin
               rv_ff[k+1] <= v_in;
            end
         end
      end
   end

   // divide each magnitude by the length
   logic [LEN_W-1:0]  dl_ff [QD+1];
   logic [ACC_W-1:0]  dr_ff [QD+1][4];
   logic [QD-1:0]     dq_ff [QD+1][4];
   hdr_type           dh_ff [QD+1];
   logic [SIDE_W-1:0] ds_ff [QD+1];
   logic [NUM_W-1:0]  num_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_in[i] = NUM_W'(rh_ff[ROOT_STEPS].mag[i]) << NUM_SH;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dl_ff[0] <= rr_ff[ROOT_STEPS][LEN_W-1:0];
         dh_ff[0] <= rh_ff[ROOT_STEPS];
         for (int i = 0; i < 4; i++) begin
            dr_ff[0][i] <= num_in[i][ACC_W-1:0];
            dq_ff[0][i] <= '0;
         end
      end
      if (reset) begin
         ds_ff[0] <= '0;
      end else if (enable) begin
         ds_ff[0] <= rs_ff[ROOT_STEPS];
      end
   end

   for (genvar j = 0; j < QD; j++) begin : g_div
      localparam int KB = QD - 1 - j;
      logic [DIV_W-1:0] dvs;
      logic [ACC_W-1:0] rem_in [4];
      logic [QD-1:0]    quo_in [4];

      always_comb begin
         dvs = DIV_W'(dl_ff[j]) << KB;
         for (int i = 0; i < 4; i++) begin
            if ({1'b0, dr_ff[j][i]} >= dvs) begin
               rem_in[i] = dr_ff[j][i] - dvs[ACC_W-1:0];
               quo_in[i] = dq_ff[j][i] | (QD'(1) << KB);
            end else begin
               rem_in[i] = dr_ff[j][i];
               quo_in[i] = dq_ff[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dl_ff[j+1] <= dl_ff[j];
            dh_ff[j+1] <= dh_ff[j];
            dr_ff[j+1] <= rem_in;
            dq_ff[j+1] <= quo_in;
         end
         if (reset) begin
            ds_ff[j+1] <= '0;
         end else if (enable) begin
            ds_ff[j+1] <= ds_ff[j];
         end
      end
   end

   // round half away from zero, restore sign
   logic [Q_W-1:0]           q_in [4];
   logic signed [OUT_W-1:0]  vo_in [4];
   logic signed [OUT_W-1:0]  vo_ff [4];
   logic [SIDE_W-1:0]        so_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_in[i] = Q_W'(dq_ff[QD][i]);
         if (((LEN_W + 1)'(dr_ff[QD][i][LEN_W-1:0]) << 1) >= (LEN_W + 1)'(dl_ff[QD])) begin
            q_in[i] = q_in[i] + Q_W'(1);
         end
         if (dh_ff[QD].zero) begin
            vo_in[i] = '0;
         end else if (dh_ff[QD].neg[i]) begin
            vo_in[i] = -OUT_W'(q_in[i]);
         end else begin
            vo_in[i] = OUT_W'(q_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vo_ff <= vo_in;
      end
      if (reset) begin
         so_ff <= '0;
      end else if (enable) begin
         so_ff <= ds_ff[QD];
      end
   end

   assign vec_out = vo_ff;
   assign side_out = so_ff;

endmodule
`default_nettype wire

// ===== sv/qnl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qnl_checker
   import qnl_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [RSP_W-1:0] rsp_r_x,
   input wire logic signed [RSP_W-1:0] rsp_r_y,
   input wire logic signed [RSP_W-1:0] rsp_r_z,
   input wire logic signed [RSP_W-1:0] rsp_r_w
);

   // input side only stalls when a result is stuck at the output
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not track the output register");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r_x) && $stable(rsp_r_y)
         && $stable(rsp_r_z) && $stable(rsp_r_w))
      else $error("stalled result changed or dropped");

endmodule

bind quaternion_nlerp_unit qnl_checker u_qnl_checker (.*);
`default_nettype wire
